// File: rtl/lccp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lccp_pkg
// Shared constants, the pending entry type and the stack cell operation codes
// for the layered code column packer.
// ----------------------------------------------------------------------------
package lccp_pkg;

  localparam int STACK_DEPTH  = 32;
  localparam int MAX_LAYERS   = 8;
  localparam int MAX_CODE_LEN = 32;

  localparam int CODE_W  = 32;
  localparam int SYM_W   = 32;
  localparam int CNT_W   = 32;
  localparam int LEN_W   = 6;
  localparam int COL_W   = 8;
  localparam int LTOP_W  = 3;
  localparam int CIDX_W  = $clog2(CODE_W);
  localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
  localparam int SLOT_W  = $clog2(MAX_LAYERS + 1);

  localparam logic [LTOP_W-1:0] LAYER_TOP_RST = LTOP_W'(3);
  localparam logic [CNT_W-1:0]  CNT_MAX       = {CNT_W{1'b1}};

  // one pending codeword tail
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  off;
    logic [CNT_W-1:0]  pos;
    logic [SYM_W-1:0]  sym;
  } pend_entry_t;

  // stack cell operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;
  localparam logic [1:0] OP_BUMP = 2'd3;

endpackage

// File: rtl/lccp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lccp_cell
// One slot of the pending stack. Shifts down on push, up on pop, and bumps
// its bit offset when it is the top slot and a bit is taken from it.
// ----------------------------------------------------------------------------
module lccp_cell
  import lccp_pkg::*;
(
  input  logic        clk,
  input  logic [1:0]  op,
  input  pend_entry_t above,
  input  pend_entry_t below,
  output pend_entry_t entry
);

  pend_entry_t entry_r;
  pend_entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (op)
      OP_HOLD: entry_nxt = entry_r;
      OP_PUSH: entry_nxt = above;
      OP_POP:  entry_nxt = below;
      OP_BUMP: entry_nxt.off = entry_r.off + LEN_W'(1);
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: rtl/layered_code_column_packer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_code_column_packer_core
// Packs prefix codewords into columns of bit layers, keeping codeword tails on
// a shifting stack of cells and tracking completion delay statistics.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | role
//  ---------+-----------------------------------------------+------------------
//  in       | in_valid/in_ready, command, symbol, codeword, | encode or drain
//           | code_length                                   |
//  out      | out_valid/out_ready, column, pending_empty,   | one per input
//           | overflow, total_delay, peak_delay, ...        |
//  cfg      | cfg_valid/cfg_ready, cfg_data                 | layer_top
//
// an encode runs ENC, FILL and DONE, a drain FILL and DONE; in FILL the bits
// come from the pending stack top (at most the layer count), one bit a cycle
// one transaction is worked on at a time; the next is accepted while a result
// still waits in the output register
// reset clears the control state and statistics and sets layer_top to 3
// a stalled output holds the block in its final state until the result leaves
// ----------------------------------------------------------------------------
module layered_code_column_packer_core
  import lccp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_codeword,
  input  logic [LEN_W-1:0]  in_code_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COL_W-1:0]  out_column,
  output logic              out_pending_empty,
  output logic              out_overflow,
  output logic [CNT_W-1:0]  out_total_delay,
  output logic [CNT_W-1:0]  out_peak_delay,
  output logic [SYM_W-1:0]  out_peak_delay_symbol,
  output logic [CNT_W-1:0]  out_extra_bits,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LTOP_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ENC  = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [LTOP_W-1:0] layer_top_r;
  logic              cmd_r;
  logic [SYM_W-1:0]  sym_r;
  logic [CODE_W-1:0] code_r;
  logic [LEN_W-1:0]  len_r;
  logic [CNT_W-1:0]  now_r, now_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              over_r, over_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  pos_cnt_r, pos_cnt_nxt;
  logic [CNT_W-1:0]  dsum_r, dsum_nxt;
  logic [CNT_W-1:0]  dpeak_r, dpeak_nxt;
  logic [SYM_W-1:0]  psym_r, psym_nxt;
  logic [CNT_W-1:0]  drain_cnt_r, drain_cnt_nxt;
  logic              out_valid_r;
  logic              load_out;

  logic [1:0]        stack_op;
  pend_entry_t       new_entry;
  pend_entry_t       cell_q [STACK_DEPTH];

  logic              in_fire;
  logic [SLOT_W-1:0] n_layers;
  logic [LEN_W-1:0]  len_clamp;
  logic [LEN_W-1:0]  n_layers_w;
  logic [COL_W-1:0]  own_bits;
  logic [LEN_W-1:0]  own_cnt;
  logic [LEN_W-1:0]  top_idx;
  logic [LEN_W-1:0]  top_off_inc;
  logic              top_bit;
  logic              top_done;
  logic [CNT_W-1:0]  delay;
  logic [CNT_W:0]    dsum_ext;
  logic [CNT_W:0]    drain_ext;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign n_layers   = SLOT_W'(layer_top_r) + SLOT_W'(1);
  assign n_layers_w = LEN_W'(n_layers);
  assign len_clamp  = (in_code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                              : in_code_length;

  // the codeword's own first bits, one lane per layer
  always_comb begin
    logic [LEN_W-1:0] idx;
    own_bits = '0;
    for (int j = 0; j < COL_W; j++) begin
      idx = len_r - LEN_W'(j + 1);
      if ((LEN_W'(j) < n_layers_w) && (LEN_W'(j) < len_r)) begin
        own_bits[j] = code_r[idx[CIDX_W-1:0]];
      end
    end
  end

  assign own_cnt = (len_r < n_layers_w) ? len_r : n_layers_w;

  // next bit of the top pending entry
  assign top_idx     = cell_q[0].len - cell_q[0].off - LEN_W'(1);
  assign top_bit     = cell_q[0].code[top_idx[CIDX_W-1:0]];
  assign top_off_inc = cell_q[0].off + LEN_W'(1);
  assign top_done    = (top_off_inc >= cell_q[0].len);
  assign delay       = now_r - cell_q[0].pos;
  assign dsum_ext    = {1'b0, dsum_r} + {1'b0, delay};
  assign drain_ext   = {1'b0, drain_cnt_r} + (CNT_W + 1)'(1);

  always_comb begin
    new_entry.code = code_r;
    new_entry.len  = len_r;
    new_entry.off  = n_layers_w;
    new_entry.pos  = now_r;
    new_entry.sym  = sym_r;
  end

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    slot_nxt      = slot_r;
    col_nxt       = col_r;
    over_nxt      = over_r;
    fill_nxt      = fill_r;
    pos_cnt_nxt   = pos_cnt_r;
    dsum_nxt      = dsum_r;
    dpeak_nxt     = dpeak_r;
    psym_nxt      = psym_r;
    drain_cnt_nxt = drain_cnt_r;
    stack_op      = OP_HOLD;
    load_out      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          slot_nxt = '0;
          col_nxt  = '0;
          over_nxt = 1'b0;
          if (in_command) begin
            now_nxt   = (pos_cnt_r != '0) ? pos_cnt_r - CNT_W'(1) : '0;
            state_nxt = ST_FILL;
          end else begin
            now_nxt   = pos_cnt_r;
            state_nxt = ST_ENC;
          end
        end
      end
      ST_ENC: begin
        col_nxt  = own_bits;
        slot_nxt = SLOT_W'(own_cnt);
        if (now_r == '0) begin
          psym_nxt = sym_r;
        end
        if (len_r > n_layers_w) begin
          if (fill_r < FILL_W'(STACK_DEPTH)) begin
            stack_op = OP_PUSH;
            fill_nxt = fill_r + FILL_W'(1);
          end else begin
            over_nxt = 1'b1;
          end
        end
        if (pos_cnt_r != CNT_MAX) begin
          pos_cnt_nxt = pos_cnt_r + CNT_W'(1);
        end
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if ((slot_r < n_layers) && (fill_r != '0)) begin
          col_nxt[slot_r[$clog2(COL_W)-1:0]] = top_bit;
          slot_nxt = slot_r + SLOT_W'(1);
          if (cmd_r) begin
            drain_cnt_nxt = drain_ext[CNT_W] ? CNT_MAX : drain_ext[CNT_W-1:0];
          end
          if (top_done) begin
            stack_op = OP_POP;
            fill_nxt = fill_r - FILL_W'(1);
            dsum_nxt = dsum_ext[CNT_W] ? CNT_MAX : dsum_ext[CNT_W-1:0];
            if (delay > dpeak_r) begin
              dpeak_nxt = delay;
              psym_nxt  = cell_q[0].sym;
            end
          end else begin
            stack_op = OP_BUMP;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [1:0]  op_i;
    pend_entry_t above_i;
    pend_entry_t below_i;

    assign op_i    = ((stack_op == OP_BUMP) && (i != 0)) ? OP_HOLD : stack_op;
    assign above_i = (i == 0) ? new_entry : cell_q[(i == 0) ? 0 : i - 1];
    assign below_i = cell_q[(i == STACK_DEPTH - 1) ? i : i + 1];

    lccp_cell u_cell (
      .clk   (clk),
      .op    (op_i),
      .above (above_i),
      .below (below_i),
      .entry (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      layer_top_r <= LAYER_TOP_RST;
      fill_r      <= '0;
      pos_cnt_r   <= '0;
      dsum_r      <= '0;
      dpeak_r     <= '0;
      psym_r      <= '0;
      drain_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pos_cnt_r   <= pos_cnt_nxt;
      dsum_r      <= dsum_nxt;
      dpeak_r     <= dpeak_nxt;
      psym_r      <= psym_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        layer_top_r <= cfg_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction payload and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_command;
      sym_r  <= in_symbol;
      code_r <= in_codeword;
      len_r  <= len_clamp;
    end
    now_r  <= now_nxt;
    slot_r <= slot_nxt;
    col_r  <= col_nxt;
    over_r <= over_nxt;
    if (load_out) begin
      out_column            <= col_r;
      out_pending_empty     <= (fill_r == '0);
      out_overflow          <= over_r;
      out_total_delay       <= dsum_r;
      out_peak_delay        <= dpeak_r;
      out_peak_delay_symbol <= psym_r;
      out_extra_bits        <= drain_cnt_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: test/layered_code_column_packer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_code_column_packer_core_tb
// Drives encode and drain transactions with random gaps on both channels,
// sweeps the layer count through every setting, predicts each column with its
// delay statistics and compares every result field in order of arrival.
// ----------------------------------------------------------------------------
module layered_code_column_packer_core_tb;
  import lccp_pkg::*;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  localparam int IDLE_NONE  = 0;
  localparam int IDLE_FULL  = 1;
  localparam int IDLE_SHORT = 2;

  localparam int SEQ_MIX   = 0;
  localparam int SEQ_FLOOD = 1;
  localparam int SEQ_DRAIN = 2;
  localparam int SEQ_NOISE = 3;

  localparam int RANDOM_ITEMS = 850;
  localparam int PHASE_ITEMS  = 50;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 500000;

  // extremes first, reset value last
  localparam logic [8*LTOP_W-1:0] LTOP_SWEEP =
    {3'd3, 3'd4, 3'd6, 3'd2, 3'd5, 3'd1, 3'd7, 3'd0};

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic             pending_empty;
    logic             overflow;
    logic [CNT_W-1:0] total_delay;
    logic [CNT_W-1:0] peak_delay;
    logic [SYM_W-1:0] peak_delay_symbol;
    logic [CNT_W-1:0] extra_bits;
  } column_result_t;

  class column_scoreboard;
    logic [LTOP_W-1:0] layer_top;
    logic [CODE_W-1:0] tail_code [STACK_DEPTH];
    logic [LEN_W-1:0]  tail_len [STACK_DEPTH];
    logic [LEN_W-1:0]  tail_off [STACK_DEPTH];
    logic [CNT_W-1:0]  tail_pos [STACK_DEPTH];
    logic [SYM_W-1:0]  tail_sym [STACK_DEPTH];
    int unsigned       fill;
    logic [CNT_W-1:0]  position;
    logic [CNT_W-1:0]  delay_total;
    logic [CNT_W-1:0]  delay_max;
    logic [SYM_W-1:0]  max_sym;
    logic [CNT_W-1:0]  drained_bits;
    column_result_t    expected_columns [$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      layer_top    = LAYER_TOP_RST;
      fill         = 0;
      position     = '0;
      delay_total  = '0;
      delay_max    = '0;
      max_sym      = '0;
      drained_bits = '0;
      mismatches   = 0;
      checked      = 0;
    endfunction

    function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    // first bit of the code is its most significant one
    function logic code_bit(logic [CODE_W-1:0] code, int unsigned len, int unsigned k);
      int unsigned shift;
      shift = len - 1 - k;
      return (shift >= CODE_W) ? 1'b0 : code[shift];
    endfunction

    function void note_delay(logic [CNT_W-1:0] d, logic [SYM_W-1:0] sym);
      delay_total = sat_add(delay_total, d);
      if (d > delay_max) begin
        delay_max = d;
        max_sym   = sym;
      end
    endfunction

    // next bit of the top tail; a finished tail leaves the stack
    function logic pop_tail_bit(logic [CNT_W-1:0] stamp);
      int unsigned t;
      logic b;
      t = fill - 1;
      b = code_bit(tail_code[t], tail_len[t], tail_off[t]);
      tail_off[t] = tail_off[t] + LEN_W'(1);
      if (tail_off[t] >= tail_len[t]) begin
        note_delay(stamp - tail_pos[t], tail_sym[t]);
        fill--;
      end
      return b;
    endfunction

    function void predict_column(logic cmd, logic [SYM_W-1:0] sym,
                                 logic [CODE_W-1:0] code, logic [LEN_W-1:0] len_in);
      int unsigned len;
      int unsigned layers;
      int unsigned j;
      logic [CNT_W-1:0] stamp;
      column_result_t r;
      len = (len_in > MAX_CODE_LEN) ? MAX_CODE_LEN : len_in;
      layers = layer_top + 1;
      if (layers > MAX_LAYERS) layers = MAX_LAYERS;
      r = '0;
      j = 0;
      if (cmd == CMD_ENCODE) begin
        stamp = position;
        if (position == '0) max_sym = sym;
        while (j < layers && j < len) begin
          r.column[j] = code_bit(code, len, j);
          j++;
        end
        if (j < len) begin
          if (fill < STACK_DEPTH) begin
            tail_code[fill] = code;
            tail_len[fill]  = LEN_W'(len);
            tail_off[fill]  = LEN_W'(j);
            tail_pos[fill]  = stamp;
            tail_sym[fill]  = sym;
            fill++;
          end else begin
            r.overflow = 1'b1;
          end
        end
        while (j < layers && fill > 0) begin
          r.column[j] = pop_tail_bit(stamp);
          j++;
        end
        if (position != CNT_MAX) position = position + 1;
      end else begin
        // a drain dates its completions to the last symbol position
        stamp = (position != '0) ? position - 1 : '0;
        while (j < layers && fill > 0) begin
          r.column[j] = pop_tail_bit(stamp);
          drained_bits = sat_add(drained_bits, 1);
          j++;
        end
      end
      r.pending_empty     = (fill == 0);
      r.total_delay       = delay_total;
      r.peak_delay        = delay_max;
      r.peak_delay_symbol = max_sym;
      r.extra_bits        = drained_bits;
      expected_columns.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
      $display("mismatch on result %0d, %s: got %h, want %h", checked, what, got_v, want_v);
      mismatches++;
    endtask

    task check_column(column_result_t got);
      column_result_t want;
      if (expected_columns.size() == 0) begin
        report_mismatch("result with nothing expected", got.column, '0);
      end else begin
        want = expected_columns.pop_front();
        if (got.column !== want.column)
          report_mismatch("column", got.column, want.column);
        if (got.pending_empty !== want.pending_empty)
          report_mismatch("pending_empty", got.pending_empty, want.pending_empty);
        if (got.overflow !== want.overflow)
          report_mismatch("overflow", got.overflow, want.overflow);
        if (got.total_delay !== want.total_delay)
          report_mismatch("total_delay", got.total_delay, want.total_delay);
        if (got.peak_delay !== want.peak_delay)
          report_mismatch("peak_delay", got.peak_delay, want.peak_delay);
        if (got.peak_delay_symbol !== want.peak_delay_symbol)
          report_mismatch("peak_delay_symbol", got.peak_delay_symbol,
                          want.peak_delay_symbol);
        if (got.extra_bits !== want.extra_bits)
          report_mismatch("extra_bits", got.extra_bits, want.extra_bits);
      end
      checked++;
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_command;
  logic [SYM_W-1:0]  in_symbol;
  logic [CODE_W-1:0] in_codeword;
  logic [LEN_W-1:0]  in_code_length;
  logic              out_valid;
  logic              out_ready;
  logic [COL_W-1:0]  out_column;
  logic              out_pending_empty;
  logic              out_overflow;
  logic [CNT_W-1:0]  out_total_delay;
  logic [CNT_W-1:0]  out_peak_delay;
  logic [SYM_W-1:0]  out_peak_delay_symbol;
  logic [CNT_W-1:0]  out_extra_bits;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [LTOP_W-1:0] cfg_data;

  column_scoreboard sb;
  int unsigned      items_sent = 0;
  int unsigned      cycle_count = 0;
  int               in_mode = IDLE_FULL;
  int               out_mode = IDLE_FULL;

  layered_code_column_packer_core uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_symbol             (in_symbol),
    .in_codeword           (in_codeword),
    .in_code_length        (in_code_length),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_column            (out_column),
    .out_pending_empty     (out_pending_empty),
    .out_overflow          (out_overflow),
    .out_total_delay       (out_total_delay),
    .out_peak_delay        (out_peak_delay),
    .out_peak_delay_symbol (out_peak_delay_symbol),
    .out_extra_bits        (out_extra_bits),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_data              (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("layered_code_column_packer_core_tb: done, errors");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(int mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 17);
      default:   return $urandom_range(0, 2);
    endcase
  endfunction

  // result side: random stall before each transaction, then check it
  initial begin : result_side
    int unsigned stall;
    column_result_t seen;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(out_mode);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      seen.column            = out_column;
      seen.pending_empty     = out_pending_empty;
      seen.overflow          = out_overflow;
      seen.total_delay       = out_total_delay;
      seen.peak_delay        = out_peak_delay;
      seen.peak_delay_symbol = out_peak_delay_symbol;
      seen.extra_bits        = out_extra_bits;
      sb.check_column(seen);
    end
  end

  // valid stays high into the next transaction when no gap is drawn
  task automatic send_item(input logic cmd, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    int unsigned gap;
    gap = draw_wait(in_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_symbol      <= sym;
    in_codeword    <= code;
    in_code_length <= len;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.predict_column(in_command, in_symbol, in_codeword, in_code_length);
    items_sent++;
  endtask

  task automatic encode_item(input logic [LEN_W-1:0] len);
    send_item(CMD_ENCODE, $urandom, $urandom, len);
  endtask

  task automatic drain_item();
    send_item(CMD_DRAIN, $urandom, $urandom, LEN_W'($urandom_range(0, 63)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_columns.size() != 0) @(posedge clk);
  endtask

  task automatic write_layer_top(input logic [LTOP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    sb.layer_top = value;
  endtask

  // mostly around the column height so tails get pushed and popped often
  function automatic logic [LEN_W-1:0] mix_length(int unsigned layers);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)       return '0;
    else if (r < 45) return LEN_W'($urandom_range(1, layers));
    else if (r < 55) return LEN_W'(layers);
    else if (r < 85) return LEN_W'($urandom_range(layers + 1, layers + 6));
    else if (r < 95) return LEN_W'($urandom_range(layers + 1, 32));
    else             return LEN_W'($urandom_range(33, 63));
  endfunction

  function automatic int pick_sequence();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)      return SEQ_MIX;
    else if (r < 62) return SEQ_FLOOD;
    else if (r < 85) return SEQ_DRAIN;
    else             return SEQ_NOISE;
  endfunction

  task automatic run_sequence(input int kind);
    int unsigned n;
    int unsigned layers;
    int unsigned i;
    bit stop;
    layers = sb.layer_top + 1;
    stop = 1'b0;
    case (kind)
      SEQ_MIX: begin
        n = $urandom_range(8, 30);
        for (i = 0; i < n; i++)
          if (sb.fill > 0 && $urandom_range(0, 5) == 0) drain_item();
          else encode_item(mix_length(layers));
      end
      SEQ_FLOOD: begin
        // long codes only: every one pushes, so the stack runs full
        n = $urandom_range(33, 40);
        for (i = 0; i < n; i++) encode_item(LEN_W'(layers + $urandom_range(1, 3)));
      end
      SEQ_DRAIN: begin
        n = $urandom_range(4, 24);
        for (i = 0; i < n && !stop; i++) begin
          stop = (sb.fill == 0);
          drain_item();
        end
      end
      default: begin
        n = $urandom_range(3, 10);
        for (i = 0; i < n; i++)
          send_item(1'($urandom_range(0, 1)), $urandom, $urandom,
                    LEN_W'($urandom_range(0, 63)));
      end
    endcase
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned base;
    int unsigned phase_start;
    logic [LTOP_W-1:0] ltop;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_ENCODE;
    in_symbol      = '0;
    in_codeword    = '0;
    in_code_length = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset layer count
    send_item(CMD_DRAIN, 32'h0000_0000, 32'h0000_0000, 6'd0);       // nothing pending
    send_item(CMD_ENCODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);      // empty code, first symbol
    send_item(CMD_ENCODE, 32'h0000_0000, 32'h0000_0001, 6'd1);
    send_item(CMD_ENCODE, 32'h1234_5678, 32'h0000_000A, 6'd4);      // exactly one column
    send_item(CMD_ENCODE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 6'd32);
    send_item(CMD_ENCODE, 32'h8000_0000, 32'h8000_0001, 6'd63);     // length cut to the max
    send_item(CMD_ENCODE, 32'h0000_0005, 32'h0000_0000, 6'd5);
    send_item(CMD_ENCODE, 32'hA5A5_A5A5, 32'h0000_0003, 6'd2);      // free layers take tails
    repeat (3) send_item(CMD_DRAIN, $urandom, $urandom, 6'd63);
    send_item(CMD_ENCODE, 32'h0000_0000, 32'hAAAA_AAAA, 6'd40);
    send_item(CMD_ENCODE, 32'h5A5A_5A5A, 32'h5555_5555, 6'd33);
    send_item(CMD_ENCODE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd31);
    send_item(CMD_ENCODE, 32'hFFFF_FFFF, 32'h0000_FFFF, 6'd16);
    send_item(CMD_ENCODE, 32'h0000_0000, 32'h0000_0000, 6'd1);
    send_item(CMD_ENCODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd3);
    repeat (2) send_item(CMD_DRAIN, $urandom, $urandom, 6'd0);

    base = items_sent;
    p = 0;
    while (items_sent < base + RANDOM_ITEMS) begin
      settle();
      ltop = (p < 8) ? LTOP_SWEEP[p*LTOP_W +: LTOP_W] : LTOP_W'($urandom_range(0, 7));
      write_layer_top(ltop);
      in_mode  = $urandom_range(IDLE_NONE, IDLE_SHORT);
      out_mode = $urandom_range(IDLE_NONE, IDLE_SHORT);
      phase_start = items_sent;
      // overflow at both extremes of the layer count
      if (p < 2) run_sequence(SEQ_FLOOD);
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < base + RANDOM_ITEMS)
        run_sequence(pick_sequence());
      p++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("layered_code_column_packer_core_tb: done, clean");
    end else begin
      $display("layered_code_column_packer_core_tb: done, errors");
    end
    $finish;
  end

endmodule
